[hw/rtl/wss_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the window signal statistics block.
package wss_pkg;

   // Window and field sizes
   localparam int MAX_WINDOW = 4096;
   localparam int SAMPLE_W   = 16;
   localparam int COUNT_W    = 13;
   localparam int SUM_W      = 29;
   localparam int SQ_SUM_W   = 43;
   localparam int MAG_SUM_W  = 28;
   localparam int SQUARE_W   = 31;
   localparam int INTERVAL_W = 16;
   localparam int ENERGY_W   = 58;
   localparam int AREA_W     = 43;
   localparam int DURATION_W = 28;

   // Square root sizes: radicand padded to an even width
   localparam int RAD_W   = 44;
   localparam int ROOT_W  = 22;
   localparam int RREM_W  = 23;

   // Sequencer step counts
   localparam int STEP_W = 6;
   localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(INTERVAL_W - 1);
   localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(SQ_SUM_W - 1);
   localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(ROOT_W - 1);

   // Division passes
   localparam logic PASS_MEAN   = 1'b0;
   localparam logic PASS_SQUARE = 1'b1;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       is_last;
   } wss_req_type;

   typedef struct packed {
      logic signed [15:0]          mean_value;
      logic [15:0]                 rms_value;
      logic [15:0]                 peak_magnitude;
      logic [ENERGY_W-1:0]         signal_energy;
      logic [AREA_W-1:0]           absolute_area;
      logic [DURATION_W-1:0]       duration;
      logic [COUNT_W-1:0]          window_count;
      logic                        result_valid;
   } wss_rsp_type;

   // Accumulator snapshot of one closed window
   typedef struct packed {
      logic signed [SUM_W-1:0] sum;
      logic [SQ_SUM_W-1:0]     square_sum;
      logic [MAG_SUM_W-1:0]    magnitude_sum;
      logic [SAMPLE_W-1:0]     peak;
      logic [COUNT_W-1:0]      count;
   } wss_window_type;

endpackage

[hw/rtl/wss_front.sv]
`timescale 1ns / 1ps
// Sample front end: magnitude and square stage, then window accumulators.
module wss_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  wss_pkg::wss_req_type    req_data,
   output logic                    push_valid,
   output wss_pkg::wss_window_type push_data,
   input  logic                    queue_full
);
   import wss_pkg::*;

   logic                       stage_valid_ff, stage_valid_in;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic [SAMPLE_W-1:0]        mag_ff;
   logic [SQUARE_W-1:0]        square_ff;
   logic                       last_ff;

   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [SQ_SUM_W-1:0]        sq_sum_ff, sq_sum_in;
   logic [MAG_SUM_W-1:0]       mag_sum_ff, mag_sum_in;
   logic [SAMPLE_W-1:0]        peak_ff, peak_in;
   logic [COUNT_W-1:0]         count_ff, count_in;

   logic [SAMPLE_W-1:0]        mag_new;
   logic [2*SAMPLE_W-1:0]      prod_new;
   logic                       accept;
   logic                       retire;
   logic                       close;
   wss_window_type             next_win;

   // Magnitude and square of the incoming sample
   assign mag_new  = req_data.sample[SAMPLE_W-1] ? SAMPLE_W'(-req_data.sample)
                                                 : req_data.sample;
   assign prod_new = mag_new * mag_new;

   // Accumulator values including the staged sample
   always_comb begin
      next_win.sum           = sum_ff + SUM_W'(sample_ff);
      next_win.square_sum    = sq_sum_ff + SQ_SUM_W'(square_ff);
      next_win.magnitude_sum = mag_sum_ff + MAG_SUM_W'(mag_ff);
      next_win.peak          = (mag_ff > peak_ff) ? mag_ff : peak_ff;
      next_win.count         = count_ff + COUNT_W'(1);
   end

   // Close on the marked sample or on a full window
   assign close     = last_ff || (next_win.count == COUNT_W'(MAX_WINDOW));
   assign retire    = stage_valid_ff && !(close && queue_full);
   assign req_stall = stage_valid_ff && !retire;
   assign accept    = req_valid && !req_stall;

   assign push_valid = retire && close;
   assign push_data  = next_win;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (retire) begin
         stage_valid_in = 1'b0;
      end
   end

   // Advance accumulators, clear them when the window closes
   always_comb begin
      sum_in     = sum_ff;
      sq_sum_in  = sq_sum_ff;
      mag_sum_in = mag_sum_ff;
      peak_in    = peak_ff;
      count_in   = count_ff;
      if (retire) begin
         if (close) begin
            sum_in     = '0;
            sq_sum_in  = '0;
            mag_sum_in = '0;
            peak_in    = '0;
            count_in   = '0;
         end else begin
            sum_in     = next_win.sum;
            sq_sum_in  = next_win.square_sum;
            mag_sum_in = next_win.magnitude_sum;
            peak_in    = next_win.peak;
            count_in   = next_win.count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         sum_ff         <= '0;
         sq_sum_ff      <= '0;
         mag_sum_ff     <= '0;
         peak_ff        <= '0;
         count_ff       <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         sum_ff         <= sum_in;
         sq_sum_ff      <= sq_sum_in;
         mag_sum_ff     <= mag_sum_in;
         peak_ff        <= peak_in;
         count_ff       <= count_in;
      end
   end

   // Hold the staged sample
   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= req_data.sample;
         mag_ff    <= mag_new;
         square_ff <= prod_new[SQUARE_W-1:0];
         last_ff   <= req_data.is_last;
      end
   end

endmodule

[hw/rtl/wss_queue.sv]
`timescale 1ns / 1ps
// Two-entry queue of closed window snapshots between front and back.
module wss_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   input  wss_pkg::wss_window_type push_data,
   output logic                    full,
   input  logic                    pop,
   output logic                    pop_valid,
   output wss_pkg::wss_window_type pop_data
);
   import wss_pkg::*;

   wss_window_type entry_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     fill_ff, fill_in;
   logic           do_push;
   logic           do_pop;

   assign full      = (fill_ff == 2'd2);
   assign pop_valid = (fill_ff != 2'd0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hw/rtl/wss_back.sv]
`timescale 1ns / 1ps
// Result sequencer: shift-add products, shared divider, square root, output register.
module wss_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [wss_pkg::INTERVAL_W-1:0] interval,
   input  logic                           win_valid,
   input  wss_pkg::wss_window_type        win_data,
   output logic                           win_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output wss_pkg::wss_rsp_type           rsp_data
);
   import wss_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_ROOT = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   wss_window_type        win_ff, win_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [INTERVAL_W-1:0] ivl_ff, ivl_in;
   logic [ENERGY_W-1:0]   energy_ff, energy_in;
   logic [AREA_W-1:0]     area_ff, area_in;
   logic [DURATION_W-1:0] dur_ff, dur_in;
   logic                  pass_ff, pass_in;
   logic [SQ_SUM_W-1:0]   work_ff, work_in;
   logic [COUNT_W-1:0]    rem_ff, rem_in;
   logic [15:0]           mean_ff, mean_in;
   logic [RAD_W-1:0]      rad_ff, rad_in;
   logic [ROOT_W-1:0]     root_ff, root_in;
   logic [RREM_W-1:0]     rrem_ff, rrem_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   wss_rsp_type           rsp_ff, rsp_in;

   logic [SUM_W-1:0]      sum_mag;
   logic                  out_free;

   logic [COUNT_W:0]      div_shift;
   logic [COUNT_W:0]      div_diff;
   logic                  div_take;
   logic [SQ_SUM_W-1:0]   div_quo;
   logic [COUNT_W-1:0]    div_rem;

   logic [RREM_W+1:0]     rt_shift;
   logic [RREM_W+1:0]     rt_trial;
   logic [RREM_W+1:0]     rt_diff;
   logic                  rt_take;

   assign sum_mag  = win_ff.sum[SUM_W-1] ? SUM_W'(-win_ff.sum) : win_ff.sum;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // One restoring divide step by the window count
   assign div_shift = {rem_ff, work_ff[SQ_SUM_W-1]};
   assign div_diff  = div_shift - {1'b0, win_ff.count};
   assign div_take  = (div_shift >= {1'b0, win_ff.count});
   assign div_rem   = div_take ? div_diff[COUNT_W-1:0] : div_shift[COUNT_W-1:0];
   assign div_quo   = {work_ff[SQ_SUM_W-2:0], div_take};

   // One digit of the square root
   assign rt_shift = {rrem_ff, rad_ff[RAD_W-1 -: 2]};
   assign rt_trial = (RREM_W+2)'({root_ff, 2'b01});
   assign rt_diff  = rt_shift - rt_trial;
   assign rt_take  = (rt_shift >= rt_trial);

   assign win_pop = (state_ff == ST_IDLE) && win_valid;

   always_comb begin
      state_in     = state_ff;
      win_in       = win_ff;
      step_in      = step_ff;
      ivl_in       = ivl_ff;
      energy_in    = energy_ff;
      area_in      = area_ff;
      dur_in       = dur_ff;
      pass_in      = pass_ff;
      work_in      = work_ff;
      rem_in       = rem_ff;
      mean_in      = mean_ff;
      rad_in       = rad_ff;
      root_in      = root_ff;
      rrem_in      = rrem_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            // Take the next closed window
            if (win_valid) begin
               win_in    = win_data;
               ivl_in    = interval;
               energy_in = '0;
               area_in   = '0;
               dur_in    = '0;
               step_in   = '0;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            // Multiply by the interval, one bit from the top each step
            energy_in = {energy_ff[ENERGY_W-2:0], 1'b0}
                      + (ivl_ff[INTERVAL_W-1] ? ENERGY_W'(win_ff.square_sum) : '0);
            area_in   = {area_ff[AREA_W-2:0], 1'b0}
                      + (ivl_ff[INTERVAL_W-1] ? AREA_W'(win_ff.magnitude_sum) : '0);
            dur_in    = {dur_ff[DURATION_W-2:0], 1'b0}
                      + (ivl_ff[INTERVAL_W-1] ? DURATION_W'(win_ff.count) : '0);
            ivl_in    = {ivl_ff[INTERVAL_W-2:0], 1'b0};
            step_in   = step_ff + STEP_W'(1);
            if (step_ff == MUL_LAST) begin
               step_in  = '0;
               work_in  = SQ_SUM_W'(sum_mag);
               rem_in   = '0;
               pass_in  = PASS_MEAN;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            work_in = div_quo;
            rem_in  = div_rem;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == DIV_LAST) begin
               step_in = '0;
               if (pass_ff == PASS_MEAN) begin
                  // Mean done: restore sign, start the mean square
                  mean_in = win_ff.sum[SUM_W-1] ? 16'(-div_quo) : div_quo[15:0];
                  work_in = win_ff.square_sum;
                  rem_in  = '0;
                  pass_in = PASS_SQUARE;
               end else begin
                  rad_in   = RAD_W'(div_quo);
                  root_in  = '0;
                  rrem_in  = '0;
                  state_in = ST_ROOT;
               end
            end
         end
         ST_ROOT: begin
            rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
            root_in = {root_ff[ROOT_W-2:0], rt_take};
            rrem_in = rt_take ? rt_diff[RREM_W-1:0] : rt_shift[RREM_W-1:0];
            step_in = step_ff + STEP_W'(1);
            if (step_ff == ROOT_LAST) begin
               step_in  = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hand over the result once the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (interval != '0) begin
                  rsp_in.mean_value     = mean_ff;
                  rsp_in.rms_value      = root_ff[15:0];
                  rsp_in.peak_magnitude = win_ff.peak;
                  rsp_in.signal_energy  = energy_ff;
                  rsp_in.absolute_area  = area_ff;
                  rsp_in.duration       = dur_ff;
                  rsp_in.window_count   = win_ff.count;
                  rsp_in.result_valid   = 1'b1;
               end else begin
                  rsp_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         pass_ff      <= PASS_MEAN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff    <= win_in;
      ivl_ff    <= ivl_in;
      energy_ff <= energy_in;
      area_ff   <= area_in;
      dur_ff    <= dur_in;
      work_ff   <= work_in;
      rem_ff    <= rem_in;
      mean_ff   <= mean_in;
      rad_ff    <= rad_in;
      root_ff   <= root_in;
      rrem_ff   <= rrem_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[hw/rtl/window_signal_statistics.sv]
`timescale 1ns / 1ps
// Top level of the window signal statistics block.
//
// Gathers sum, sum of squares, sum of magnitudes, peak magnitude and count over a
// window of signed samples and emits one result when a sample marked is_last
// arrives or the window reaches 4096 samples. The front end takes one sample per
// cycle unless a closing window meets a full queue (a magnitude/square stage,
// then the accumulators). Each closed window is handed through a two-entry
// queue to a sequencer that takes the window, runs 16 shift-add steps for the
// interval products, two 43-step divisions by the count on one shared divider
// and 22 square-root steps, then loads the output register. Windows shorter than
// its run stall the input once the queue is full. A sample_interval of zero
// yields an all-zero result. Write csr_write_en only while no window is in flight.
module window_signal_statistics (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  wss_pkg::wss_req_type           req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output wss_pkg::wss_rsp_type           rsp_data,
   input  logic                           csr_write_en,
   input  logic [wss_pkg::INTERVAL_W-1:0] csr_write_data
);
   import wss_pkg::*;

   logic [INTERVAL_W-1:0] interval_ff;
   logic                  push_valid;
   wss_window_type        push_data;
   logic                  queue_full;
   logic                  pop;
   logic                  pop_valid;
   wss_window_type        pop_data;

   // Hold the sample interval register
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= INTERVAL_W'(1);
      end else if (csr_write_en) begin
         interval_ff <= csr_write_data;
      end
   end

   wss_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   wss_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data)
   );

   wss_back u_back (
      .clock     (clock),
      .reset     (reset),
      .interval  (interval_ff),
      .win_valid (pop_valid),
      .win_data  (pop_data),
      .win_pop   (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
